### hdl/bsoc_pkg.sv
// ----------------------------------------------------------------------------
// bsoc_pkg: shared constants, tables and types
// Widths of the scaling datapath, the divider layout, the charge curve
// and the configuration register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bsoc_pkg;

    // ADC resolution; the sample field itself is always 12 bits wide
    localparam int ADC_BITS   = 12;
    localparam int RAW_W      = 12;
    localparam int FS_W       = 16;
    localparam int RATIO_W    = 8;
    localparam int MUL1_W     = RAW_W + FS_W;
    localparam int VADC_W     = MUL1_W - ADC_BITS;
    localparam int PROD_W     = VADC_W + RATIO_W;

    // Divider: four quotient bits resolved per pipeline stage
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (PROD_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_STAGES * DIV_STEP;

    // Output widths and the compare width of the charge lookup
    localparam int MV_W       = 24;
    localparam int CMP_W      = (PROD_W > MV_W) ? PROD_W : MV_W;
    localparam int PCT_W      = 7;
    localparam logic [MV_W-1:0] BAT_MV_MAX = 24'd16711425;

    // Two multiplier stages, the divider, two lookup stages
    localparam int LATENCY    = 2 + DIV_STAGES + 2;

    // Discharge curve: breakpoints from the top, in millivolts
    localparam int SOC_POINTS = 11;
    localparam int SEGS       = SOC_POINTS - 1;
    localparam int SEG_W      = 4;
    localparam int TBL_MV_W   = 13;
    localparam int OFS_W      = 9;
    localparam int STEP_W     = 6;
    localparam int THR_W      = 10;
    localparam int FRAC_W     = 4;
    localparam int FRAC_MAX   = 9;

    localparam logic [TBL_MV_W-1:0] SOC_MV [SOC_POINTS] = '{
        13'd4200, 13'd4050, 13'd3950, 13'd3850, 13'd3800, 13'd3750,
        13'd3700, 13'd3650, 13'd3550, 13'd3400, 13'd3000
    };

    // Percentage at the low end of each segment
    localparam logic [PCT_W-1:0] SEG_PCT_LO [SEGS] = '{
        7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
    };

    // Millivolts per whole percent inside each segment (span / 10)
    localparam logic [STEP_W-1:0] SEG_STEP [SEGS] = '{
        6'd15, 6'd10, 6'd10, 6'd5, 6'd5, 6'd5, 6'd5, 6'd10, 6'd15, 6'd40
    };

    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    // Voltage class found by the segment search
    localparam logic [1:0] CLS_EMPTY = 2'd0;
    localparam logic [1:0] CLS_FULL  = 2'd1;
    localparam logic [1:0] CLS_SEG   = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV_NUM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV_DEN    = 2'd2;

    localparam logic [FS_W-1:0]    FS_RESET  = 16'd3600;
    localparam logic [RATIO_W-1:0] NUM_RESET = 8'd2;
    localparam logic [RATIO_W-1:0] DEN_RESET = 8'd1;

    // Scaling settings as seen by the datapath
    typedef struct packed {
        logic [FS_W-1:0]    full_scale;
        logic [RATIO_W-1:0] num;
        logic [RATIO_W-1:0] den;
    } t_cfg;

endpackage

`default_nettype wire

### hdl/bsoc_scale.sv
// ----------------------------------------------------------------------------
// bsoc_scale: ADC sample to scaled dividend
// Stage one multiplies the sample by full scale, stage two drops the ADC
// fraction bits and multiplies by the divider numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module bsoc_scale (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire [bsoc_pkg::RAW_W-1:0]    i_raw,
    input  bsoc_pkg::t_cfg               i_cfg,
    output logic                         o_valid,
    output logic [bsoc_pkg::PROD_W-1:0]  o_prod
);
    import bsoc_pkg::*;

    logic              r_v1;
    logic              r_v2;
    logic [MUL1_W-1:0] r_p1;
    logic [PROD_W-1:0] r_p2;
    logic [VADC_W-1:0] v_adc;

    // Truncate to millivolts at the pin
    assign v_adc = r_p1[MUL1_W-1:ADC_BITS];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Multiply by full scale, then by the divider numerator
    always_ff @(posedge i_clk) begin
        r_p1 <= MUL1_W'(i_raw) * MUL1_W'(i_cfg.full_scale);
        r_p2 <= PROD_W'(v_adc) * PROD_W'(i_cfg.num);
    end

    assign o_valid = r_v2;
    assign o_prod  = r_p2;

endmodule

`default_nettype wire

### hdl/bsoc_div.sv
// ----------------------------------------------------------------------------
// bsoc_div: pipelined restoring divider
// Divides the scaled product by the divider denominator, resolving a few
// quotient bits per stage, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module bsoc_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire [bsoc_pkg::PROD_W-1:0]   i_dividend,
    input  wire [bsoc_pkg::RATIO_W-1:0]  i_den,
    output logic                         o_valid,
    output logic [bsoc_pkg::PROD_W-1:0]  o_quot
);
    import bsoc_pkg::*;

    // Stage inputs: index 0 is the module input, index s+1 is stage s
    logic               a_vld [DIV_STAGES+1];
    logic [DIV_W-1:0]   a_dvd [DIV_STAGES+1];
    logic [DIV_W-1:0]   a_quo [DIV_STAGES+1];
    logic [RATIO_W-1:0] a_rem [DIV_STAGES+1];

    logic               r_vld [DIV_STAGES];
    logic [DIV_W-1:0]   r_dvd [DIV_STAGES];
    logic [DIV_W-1:0]   r_quo [DIV_STAGES];
    logic [RATIO_W-1:0] r_rem [DIV_STAGES];

    logic [DIV_W-1:0]   n_dvd [DIV_STAGES];
    logic [DIV_W-1:0]   n_quo [DIV_STAGES];
    logic [RATIO_W-1:0] n_rem [DIV_STAGES];

    assign a_vld[0] = i_valid;
    assign a_dvd[0] = DIV_W'(i_dividend);
    assign a_quo[0] = '0;
    assign a_rem[0] = '0;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_link
        assign a_vld[s+1] = r_vld[s];
        assign a_dvd[s+1] = r_dvd[s];
        assign a_quo[s+1] = r_quo[s];
        assign a_rem[s+1] = r_rem[s];
    end

    // Shift in dividend bits, subtract the denominator where it fits
    always_comb begin
        logic [RATIO_W:0]   t;
        logic [RATIO_W-1:0] rem;
        logic [DIV_W-1:0]   dvd;
        logic [DIV_W-1:0]   quo;
        logic               qbit;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = a_rem[s];
            dvd = a_dvd[s];
            quo = a_quo[s];
            for (int b = 0; b < DIV_STEP; b++) begin
                t   = {rem, dvd[DIV_W-1]};
                dvd = {dvd[DIV_W-2:0], 1'b0};
                if (t >= {1'b0, i_den}) begin
                    rem  = RATIO_W'(t - {1'b0, i_den});
                    qbit = 1'b1;
                end else begin
                    rem  = t[RATIO_W-1:0];
                    qbit = 1'b0;
                end
                quo = {quo[DIV_W-2:0], qbit};
            end
            n_rem[s] = rem;
            n_dvd[s] = dvd;
            n_quo[s] = quo;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vld[s] <= a_vld[s];
            end
        end
    end

    // Advance partial results
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_dvd[s] <= n_dvd[s];
            r_quo[s] <= n_quo[s];
            r_rem[s] <= n_rem[s];
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_quo[DIV_STAGES-1][PROD_W-1:0];

endmodule

`default_nettype wire

### hdl/bsoc_charge.sv
// ----------------------------------------------------------------------------
// bsoc_charge: state of charge lookup
// Stage one saturates the voltage and finds the curve segment; stage two
// counts whole percent steps above the segment floor.
// ----------------------------------------------------------------------------
`default_nettype none

module bsoc_charge (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire [bsoc_pkg::PROD_W-1:0]   i_mv,
    output logic                         o_valid,
    output logic [bsoc_pkg::PCT_W-1:0]   o_charge,
    output logic [bsoc_pkg::MV_W-1:0]    o_mv
);
    import bsoc_pkg::*;

    logic [CMP_W-1:0]  v_ext;
    logic [1:0]        n_cls;
    logic [SEG_W-1:0]  n_seg;
    logic [OFS_W-1:0]  n_ofs;
    logic [MV_W-1:0]   n_mv;
    logic [FRAC_W-1:0] frac;
    logic [PCT_W-1:0]  n_charge;

    logic              r_va;
    logic              r_vb;
    logic [1:0]        r_cls;
    logic [SEG_W-1:0]  r_seg;
    logic [OFS_W-1:0]  r_ofs;
    logic [MV_W-1:0]   r_mv_a;
    logic [MV_W-1:0]   r_mv_b;
    logic [PCT_W-1:0]  r_charge;

    assign v_ext = CMP_W'(i_mv);

    // Saturate the reported voltage
    assign n_mv = (v_ext > CMP_W'(BAT_MV_MAX)) ? BAT_MV_MAX : v_ext[MV_W-1:0];

    // Classify the voltage and find its segment and offset above the floor
    always_comb begin
        n_seg = '0;
        n_ofs = '0;
        for (int i = 0; i < SEGS; i++) begin
            if (v_ext >= CMP_W'(SOC_MV[i+1]) && v_ext < CMP_W'(SOC_MV[i])) begin
                n_seg = SEG_W'(i);
                n_ofs = OFS_W'(v_ext[TBL_MV_W-1:0] - SOC_MV[i+1]);
            end
        end
        if (v_ext >= CMP_W'(SOC_MV[0])) begin
            n_cls = CLS_FULL;
        end else if (v_ext < CMP_W'(SOC_MV[SOC_POINTS-1])) begin
            n_cls = CLS_EMPTY;
        end else begin
            n_cls = CLS_SEG;
        end
    end

    // Count percent thresholds passed inside the segment
    always_comb begin
        logic [THR_W-1:0] thr;
        frac = '0;
        for (int k = 1; k <= FRAC_MAX; k++) begin
            thr = THR_W'(SEG_STEP[r_seg]) * THR_W'(k);
            if (THR_W'(r_ofs) >= thr) begin
                frac = frac + FRAC_W'(1);
            end
        end
        unique case (r_cls)
            CLS_FULL:  n_charge = PCT_FULL;
            CLS_EMPTY: n_charge = PCT_EMPTY;
            default:   n_charge = SEG_PCT_LO[r_seg] + PCT_W'(frac);
        endcase
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    // Hold segment data, then the finished result
    always_ff @(posedge i_clk) begin
        r_cls    <= n_cls;
        r_seg    <= n_seg;
        r_ofs    <= n_ofs;
        r_mv_a   <= n_mv;
        r_mv_b   <= r_mv_a;
        r_charge <= n_charge;
    end

    assign o_valid  = r_vb;
    assign o_charge = r_charge;
    assign o_mv     = r_mv_b;

endmodule

`default_nettype wire

### hdl/battery_soc_from_adc.sv
// ----------------------------------------------------------------------------
// battery_soc_from_adc: battery voltage and state of charge from ADC samples
// Scales a raw sample to pin millivolts, applies the divider ratio and
// interpolates the charge percentage on a fixed discharge curve.
//
//   Channel   Direction  Handshake                  Payload
//   sample    in         start high, busy low       i_raw_sample
//   result    out        o_valid, one cycle         o_charge_percent, o_battery_mv
//   config    in         i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request is accepted every cycle; busy stays low. Each result passes
// through 2 multiplier stages, one divider stage per four quotient bits and
// 2 lookup stages. Results hold for exactly one cycle and are never held
// back. Synchronous reset flushes all requests in flight and restores the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_soc_from_adc (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [bsoc_pkg::RAW_W-1:0]        i_raw_sample,
    output logic                             o_valid,
    output logic [bsoc_pkg::PCT_W-1:0]       o_charge_percent,
    output logic [bsoc_pkg::MV_W-1:0]        o_battery_mv,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [bsoc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [bsoc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bsoc_pkg::*;

    logic [FS_W-1:0]    r_full_scale;
    logic [RATIO_W-1:0] r_num;
    logic [RATIO_W-1:0] r_den;
    t_cfg               cfg;

    logic               scl_valid;
    logic [PROD_W-1:0]  scl_prod;
    logic               div_valid;
    logic [PROD_W-1:0]  div_quot;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FS_RESET;
            r_num        <= NUM_RESET;
            r_den        <= DEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                CFG_DIV_NUM:    r_num        <= i_cfg_data[RATIO_W-1:0];
                CFG_DIV_DEN:    r_den        <= i_cfg_data[RATIO_W-1:0];
                default:        r_num        <= r_num;
            endcase
        end
    end

    // Treat a zero denominator as one
    always_comb begin
        cfg.full_scale = r_full_scale;
        cfg.num        = r_num;
        cfg.den        = (r_den == '0) ? RATIO_W'(1) : r_den;
    end

    bsoc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_raw   (i_raw_sample),
        .i_cfg   (cfg),
        .o_valid (scl_valid),
        .o_prod  (scl_prod)
    );

    bsoc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (scl_valid),
        .i_dividend (scl_prod),
        .i_den      (cfg.den),
        .o_valid    (div_valid),
        .o_quot     (div_quot)
    );

    bsoc_charge u_charge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_valid),
        .i_mv     (div_quot),
        .o_valid  (o_valid),
        .o_charge (o_charge_percent),
        .o_mv     (o_battery_mv)
    );

endmodule

`default_nettype wire

### hdl/bsoc_checker.sv
// ----------------------------------------------------------------------------
// bsoc_checker: port-level checks for battery_soc_from_adc
// Checks result timing against accepted requests and the consistency of
// the charge with the reported voltage.
// ----------------------------------------------------------------------------
`default_nettype none

module bsoc_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    input  wire                              busy,
    input  wire                              o_valid,
    input  wire [bsoc_pkg::PCT_W-1:0]        o_charge_percent,
    input  wire [bsoc_pkg::MV_W-1:0]         o_battery_mv
);
    import bsoc_pkg::*;

    // Every accepted request yields a result after the pipeline latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted request produced no result");

    // No result without a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LATENCY !o_valid)
        else $error("result without a request");

    // Charge stays within range
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_charge_percent <= PCT_FULL))
        else $error("charge above full");

    // Voltage at or above the top point reads full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_battery_mv >= MV_W'(SOC_MV[0])) |-> (o_charge_percent == PCT_FULL))
        else $error("high voltage not reported full");

    // Voltage at or below the bottom point reads empty
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_battery_mv <= MV_W'(SOC_MV[SOC_POINTS-1]))
            |-> (o_charge_percent == PCT_EMPTY))
        else $error("low voltage not reported empty");

endmodule

bind battery_soc_from_adc bsoc_checker u_bsoc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_charge_percent (o_charge_percent),
    .o_battery_mv     (o_battery_mv)
);

`default_nettype wire
